// ===== src/slo_pkg.sv =====
// slo_pkg: shared widths, register map, status codes and controller/datapath
// interface types for the struct layout engine. No dependencies.
package slo_pkg;

    // Defaults for the top-level parameters
    localparam int OFFSET_BITS_DEF = 16;
    localparam int ALIGN_MAX_DEF   = 64;

    // Fixed field widths
    localparam int SIZE_W   = 16;
    localparam int ALIGN_W  = 7;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REGIDX_W = 2;

    // Alignment forced on every member in argument-stack mode
    localparam logic [ALIGN_W-1:0] ARG_STACK_ALIGN = 7'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [REGIDX_W-1:0] REG_PACK         = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_STRUCT_ALIGN = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_UNION        = 2'd2;
    localparam logic [REGIDX_W-1:0] REG_ARG_STACK    = 2'd3;

    localparam logic [ALIGN_W-1:0] PACK_RESET = 7'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INCOMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 2'd2;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // capture input beat, open struct if needed
        logic div_start;  // launch remainder unit
        logic div_fin;    // divider operands: 1 = final size, 0 = member offset
        logic off_step;   // round running offset up to member alignment
        logic upd_step;   // advance running offset/size, latch errors
        logic fin_step;   // round size up to struct alignment
        logic out_load;   // move result into output register
    } slo_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
        logic last_item;
    } slo_stat_t;

endpackage

// ===== src/slo_div.sv =====
// slo_div: restoring remainder unit, one dividend bit per cycle.
// Uses no package items.
module slo_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/slo_dp.sv =====
// slo_dp: layout datapath - running offset/size, alignment and pack tracking,
// error latch, output register. Depends on slo_pkg and slo_div.
module slo_dp
    import slo_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int ALIGN_MAX   = ALIGN_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  slo_cmd_t            cmd,
    output slo_stat_t           stat,
    // configuration
    input  logic [ALIGN_W-1:0]  cfg_pack,
    input  logic [ALIGN_W-1:0]  cfg_struct_align,
    input  logic                cfg_union,
    input  logic                cfg_arg_stack,
    // input beat
    input  logic [SIZE_W-1:0]   s_member_size,
    input  logic [ALIGN_W-1:0]  s_member_align,
    input  logic [ALIGN_W-1:0]  s_member_explicit_align,
    input  logic                s_member_complete,
    input  logic                s_last_member,
    // result beat
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SIZE_W-1:0]   m_member_offset,
    output logic [SIZE_W-1:0]   m_struct_size,
    output logic [ALIGN_W-1:0]  m_struct_align,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last
);

    localparam int AW  = $clog2(ALIGN_MAX + 1);
    localparam int VW  = (OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W;
    localparam int CAW = ALIGN_W + AW;
    localparam logic [VW:0] SAT = (VW+1)'((64'd1 << OFFSET_BITS) - 64'd1);

    function automatic logic [AW-1:0] clamp_a(input logic [ALIGN_W-1:0] a);
        logic [CAW-1:0] ax;
        ax = CAW'(a);
        if (a == '0)
            return AW'(1);
        else if (ax > CAW'(ALIGN_MAX))
            return AW'(ALIGN_MAX);
        else
            return AW'(a);
    endfunction

    // state
    logic                started_reg;
    logic                m_valid_reg;
    logic [VW-1:0]       run_off_reg;
    logic [VW-1:0]       run_size_reg;
    logic [VW-1:0]       off_reg;
    logic [VW-1:0]       fin_reg;
    logic [AW-1:0]       max_align_reg;
    logic [AW-1:0]       eff_pack_reg;
    logic [AW-1:0]       ia_reg;
    logic [STATUS_W-1:0] err_reg;
    logic                ovf_reg;
    logic [SIZE_W-1:0]   msize_reg;
    logic                complete_reg;
    logic                last_reg;
    logic [SIZE_W-1:0]   m_offset_reg;
    logic [SIZE_W-1:0]   m_size_reg;
    logic [ALIGN_W-1:0]  m_align_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_last_reg;

    // struct-open values and member alignment
    logic [ALIGN_W-1:0] pk7, mexpl;
    logic [AW-1:0]      ea_c, pk_c, begin_pack, begin_max;
    logic [AW-1:0]      base_pack, base_max, ia, new_pack, new_max;
    logic [AW-1:0]      align_out;

    always_comb begin
        pk7        = cfg_arg_stack ? ARG_STACK_ALIGN : cfg_pack;
        ea_c       = clamp_a(cfg_struct_align);
        pk_c       = clamp_a(pk7);
        begin_pack = (cfg_struct_align != '0 && ea_c > pk_c) ? ea_c : pk_c;
        begin_max  = (cfg_struct_align != '0) ? ea_c : AW'(1);
        base_pack  = started_reg ? eff_pack_reg : begin_pack;
        base_max   = started_reg ? max_align_reg : begin_max;
        mexpl      = cfg_arg_stack ? ARG_STACK_ALIGN : s_member_explicit_align;
        ia         = (mexpl != '0) ? clamp_a(mexpl) : clamp_a(s_member_align);
        new_pack   = (mexpl != '0 && ia > base_pack) ? ia : base_pack;
        new_max    = (ia > base_max) ? ia : base_max;
    end

    assign align_out = (max_align_reg < eff_pack_reg) ? max_align_reg : eff_pack_reg;

    // remainder unit
    logic          div_done;
    logic [AW-1:0] div_rem;

    slo_div #(
        .NUM_W (VW),
        .DEN_W (AW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (cmd.div_fin ? run_size_reg : run_off_reg),
        .den     (cmd.div_fin ? align_out : ia_reg),
        .done    (div_done),
        .rem     (div_rem)
    );

    // round-up and advance arithmetic
    logic [VW:0] off_sum, end_sum, fin_sum, msize_x;
    logic        end_ovf, ovf_any;

    always_comb begin
        off_sum = (VW+1)'(run_off_reg) +
                  ((div_rem == '0) ? '0 : (VW+1)'(ia_reg - div_rem));
        fin_sum = (VW+1)'(run_size_reg) +
                  ((div_rem == '0) ? '0 : (VW+1)'(align_out - div_rem));
        msize_x = (VW+1)'(msize_reg);
        end_sum = (VW+1)'(off_reg) + msize_x;
        end_ovf = (end_sum > SAT);
        ovf_any = ovf_reg | (!cfg_union & end_ovf);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ia_reg        <= ia;
            eff_pack_reg  <= new_pack;
            max_align_reg <= new_max;
            run_off_reg   <= started_reg ? run_off_reg : '0;
            run_size_reg  <= started_reg ? run_size_reg : '0;
            err_reg       <= started_reg ? err_reg : STAT_OK;
            ovf_reg       <= 1'b0;
            msize_reg     <= s_member_size;
            complete_reg  <= s_member_complete;
            last_reg      <= s_last_member;
        end
        if (cmd.off_step) begin
            if (off_sum > SAT) begin
                off_reg <= SAT[VW-1:0];
                ovf_reg <= 1'b1;
            end else begin
                off_reg <= off_sum[VW-1:0];
            end
        end
        if (cmd.upd_step) begin
            if (cfg_union) begin
                if ((VW+1)'(run_size_reg) < msize_x)
                    run_size_reg <= msize_x[VW-1:0];
            end else begin
                run_off_reg  <= end_ovf ? SAT[VW-1:0] : end_sum[VW-1:0];
                run_size_reg <= end_ovf ? SAT[VW-1:0] : end_sum[VW-1:0];
            end
            if (err_reg == STAT_OK) begin
                if (!complete_reg)
                    err_reg <= STAT_INCOMPLETE;
                else if (ovf_any)
                    err_reg <= STAT_OVERFLOW;
            end
        end
        if (cmd.fin_step) begin
            if (fin_sum > SAT) begin
                fin_reg <= SAT[VW-1:0];
                if (err_reg == STAT_OK)
                    err_reg <= STAT_OVERFLOW;
            end else begin
                fin_reg <= fin_sum[VW-1:0];
            end
        end
        if (cmd.out_load) begin
            m_offset_reg <= off_reg[SIZE_W-1:0];
            m_size_reg   <= last_reg ? fin_reg[SIZE_W-1:0] : run_size_reg[SIZE_W-1:0];
            m_align_reg  <= ALIGN_W'(align_out);
            m_status_reg <= err_reg;
            m_last_reg   <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load)
                started_reg <= 1'b1;
            else if (cmd.out_load && last_reg)
                started_reg <= 1'b0;
            if (cmd.out_load)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.last_item = last_reg;

    assign m_valid         = m_valid_reg;
    assign m_member_offset = m_offset_reg;
    assign m_struct_size   = m_size_reg;
    assign m_struct_align  = m_align_reg;
    assign m_status        = m_status_reg;
    assign m_last          = m_last_reg;

endmodule

// ===== src/slo_ctrl.sv =====
// slo_ctrl: sequencer for one member: capture, offset round-up, advance,
// final round-up on the last member, hand-off to the output register. Uses slo_pkg.
module slo_ctrl
    import slo_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  slo_stat_t stat,
    output slo_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_OSTART = 3'd1;
    localparam logic [2:0] S_OWAIT  = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_FSTART = 3'd4;
    localparam logic [2:0] S_FWAIT  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_OSTART;
                end
            end
            S_OSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_OWAIT;
            end
            S_OWAIT: begin
                if (stat.div_done) begin
                    cmd.off_step = 1'b1;
                    state_next   = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd_step = 1'b1;
                state_next   = stat.last_item ? S_FSTART : S_OUT;
            end
            S_FSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_fin   = 1'b1;
                state_next    = S_FWAIT;
            end
            S_FWAIT: begin
                if (stat.div_done) begin
                    cmd.fin_step = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/struct_layout_offsets.sv =====
// struct_layout_offsets: top level - APB register file, sequencer and datapath.
// Depends on slo_pkg, slo_ctrl, slo_dp (and slo_div below it).
//
// Usage:
//   Members of one C struct or union enter on the s_ channel, one per beat, the
//   final one flagged by s_last_member. Each beat yields exactly one result beat
//   on the m_ channel: the member's offset, the running size (the size rounded
//   up to the struct alignment on the last member), the struct alignment capped
//   by the effective pack, a sticky per-struct status and the last flag.
//   The remainder unit retires one dividend bit per cycle and runs once per
//   member, and a second time for the final size.
//   One member is in flight at a time; s_ready is high while the sequencer is
//   idle, also while a finished result still waits in the output register.
//   If the receiver stalls, the result holds in the output register and the next
//   member is worked up to the hand-off, where it waits for the register to free.
//   Reset (aresetn low, synchronous) empties the output, clears the struct-open
//   flag and returns pack to 8, the other registers to 0. Pack and struct-alignment
//   writes are picked up when the next struct opens; union and arg-stack per member.
module struct_layout_offsets
    import slo_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int ALIGN_MAX   = ALIGN_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // member input
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SIZE_W-1:0]   s_member_size,
    input  logic [ALIGN_W-1:0]  s_member_align,
    input  logic [ALIGN_W-1:0]  s_member_explicit_align,
    input  logic                s_member_complete,
    input  logic                s_last_member,
    // layout result
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SIZE_W-1:0]   m_member_offset,
    output logic [SIZE_W-1:0]   m_struct_size,
    output logic [ALIGN_W-1:0]  m_struct_align,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last
);

    // Register file
    logic [ALIGN_W-1:0]  pack_reg;
    logic [ALIGN_W-1:0]  salign_reg;
    logic                union_reg;
    logic                argstk_reg;
    logic                wr_en;
    logic [REGIDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_reg   <= PACK_RESET;
            salign_reg <= '0;
            union_reg  <= 1'b0;
            argstk_reg <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PACK:         pack_reg   <= pwdata[ALIGN_W-1:0];
                REG_STRUCT_ALIGN: salign_reg <= pwdata[ALIGN_W-1:0];
                REG_UNION:        union_reg  <= pwdata[0];
                REG_ARG_STACK:    argstk_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read mux, combinational
    always_comb begin
        case (reg_idx)
            REG_PACK:         prdata = DATA_W'(pack_reg);
            REG_STRUCT_ALIGN: prdata = DATA_W'(salign_reg);
            REG_UNION:        prdata = DATA_W'(union_reg);
            REG_ARG_STACK:    prdata = DATA_W'(argstk_reg);
            default:          prdata = '0;
        endcase
    end

    // Sequencer <-> datapath
    slo_cmd_t  cmd;
    slo_stat_t stat;

    slo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    slo_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .ALIGN_MAX   (ALIGN_MAX)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .stat                    (stat),
        .cfg_pack                (pack_reg),
        .cfg_struct_align        (salign_reg),
        .cfg_union               (union_reg),
        .cfg_arg_stack           (argstk_reg),
        .s_member_size           (s_member_size),
        .s_member_align          (s_member_align),
        .s_member_explicit_align (s_member_explicit_align),
        .s_member_complete       (s_member_complete),
        .s_last_member           (s_last_member),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_member_offset         (m_member_offset),
        .m_struct_size           (m_struct_size),
        .m_struct_align          (m_struct_align),
        .m_status                (m_status),
        .m_last                  (m_last)
    );

endmodule

// ===== src/slo_chk.sv =====
// slo_chk: port-level checks for struct_layout_offsets, bound to the top level.
// Uses slo_pkg.
module slo_chk
    import slo_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [SIZE_W-1:0]   m_member_offset,
    input logic [SIZE_W-1:0]   m_struct_size,
    input logic [ALIGN_W-1:0]  m_struct_align,
    input logic [STATUS_W-1:0] m_status,
    input logic                m_last
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_member_offset)
            && $stable(m_struct_size) && $stable(m_status) && $stable(m_last))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_INCOMPLETE
            || m_status == STAT_OVERFLOW))
        else $error("undefined status code");

    a_align_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_struct_align != '0)
        else $error("struct alignment of zero");

    // one member in flight: no new input beat on the cycle after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second member taken while one is in flight");

endmodule

bind struct_layout_offsets slo_chk u_slo_chk (.*);

// ===== bench/tb_struct_layout_offsets.sv =====
`timescale 1ns / 1ps
// tb_struct_layout_offsets: self-checking bench for the struct layout engine.
// Drives members and APB register writes, predicts each result beat locally.
// Depends on slo_pkg and struct_layout_offsets.
module tb_struct_layout_offsets;
    import slo_pkg::*;

    localparam int unsigned SAT_MAX = (1 << OFFSET_BITS_DEF) - 1;
    // Worst beat is a last member behind a receiver stalling 71% of cycles;
    // a quiet run as long as STALL_LIMIT means the block is hung.
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 80;     // comfortably past the last-member latency
    localparam int SHOWN_MAX   = 10;

    // One member as it enters on the s_ channel
    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [ALIGN_W-1:0] align;
        logic [ALIGN_W-1:0] expl;
        logic               complete;
        logic               last;
    } member_t;

    // One result beat on the m_ channel
    typedef struct packed {
        logic [SIZE_W-1:0]   offset;
        logic [SIZE_W-1:0]   size;
        logic [ALIGN_W-1:0]  align;
        logic [STATUS_W-1:0] status;
        logic                last;
    } placement_t;

    typedef enum logic {ROW_CFG, ROW_MEMBER} row_kind_t;

    // Directed table row: a register write or a member, optionally with a
    // hand-written expected placement
    typedef struct {
        row_kind_t           kind;
        logic [REGIDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]   reg_val;
        member_t             mem;
        bit                  pinned;
        placement_t          want;
    } row_t;

    typedef struct {
        bit         pinned;
        placement_t want;
    } pin_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SIZE_W-1:0]   s_member_size           = '0;
    logic [ALIGN_W-1:0]  s_member_align          = '0;
    logic [ALIGN_W-1:0]  s_member_explicit_align = '0;
    logic                s_member_complete       = 1'b0;
    logic                s_last_member           = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SIZE_W-1:0]   m_member_offset;
    logic [SIZE_W-1:0]   m_struct_size;
    logic [ALIGN_W-1:0]  m_struct_align;
    logic [STATUS_W-1:0] m_status;
    logic                m_last;

    struct_layout_offsets DUT (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_member_size           (s_member_size),
        .s_member_align          (s_member_align),
        .s_member_explicit_align (s_member_explicit_align),
        .s_member_complete       (s_member_complete),
        .s_last_member           (s_last_member),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_member_offset         (m_member_offset),
        .m_struct_size           (m_struct_size),
        .m_struct_align          (m_struct_align),
        .m_status                (m_status),
        .m_last                  (m_last)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Layout predictor: local copy of the registers and the struct state
    // ------------------------------------------------------------------
    logic [ALIGN_W-1:0]  cfg_pack         = PACK_RESET;
    logic [ALIGN_W-1:0]  cfg_struct_align = '0;
    logic                cfg_union        = 1'b0;
    logic                cfg_arg_stack    = 1'b0;

    logic [SIZE_W:0]     lay_offset;
    logic [SIZE_W:0]     lay_size;
    logic [ALIGN_W-1:0]  lay_max_align;
    logic [ALIGN_W-1:0]  lay_pack;
    logic [STATUS_W-1:0] lay_err;
    bit                  lay_open = 1'b0;   // cleared after each last member

    placement_t placement_q[$];   // expected result beats, oldest first
    pin_t       pinned_q[$];      // one entry per member handed to the driver
    row_t       directed[$];

    int tx_idle_pct  = 10;
    int rx_idle_pct  = 71;
    int fail_count   = 0;
    int stall_cycles = 0;

    // zero means 1, anything past the ceiling is clamped to it
    function automatic logic [ALIGN_W-1:0] clamp_al(input int unsigned a);
        if (a == 0)
            return ALIGN_W'(1);
        if (a > ALIGN_MAX_DEF)
            return ALIGN_W'(ALIGN_MAX_DEF);
        return ALIGN_W'(a);
    endfunction

    // general round-up, alignment need not be a power of two
    function automatic int unsigned ceil_mult(input int unsigned v, input int unsigned a);
        return ((v + a - 1) / a) * a;
    endfunction

    // pack and struct alignment are sampled when a struct opens
    function automatic void open_struct();
        int unsigned pk;
        int unsigned ea;
        pk = cfg_arg_stack ? 32'(ARG_STACK_ALIGN) : 32'(cfg_pack);
        ea = 32'(cfg_struct_align);
        lay_offset = '0;
        lay_size   = '0;
        lay_err    = STAT_OK;
        if (ea > 0) begin
            ea = 32'(clamp_al(ea));
            if (pk < ea)
                pk = ea;
            lay_max_align = ALIGN_W'(ea);
        end else begin
            lay_max_align = ALIGN_W'(1);
        end
        lay_pack = clamp_al(pk);
        lay_open = 1'b1;
    endfunction

    function automatic placement_t place_member(input member_t m);
        int unsigned ia;
        int unsigned off;
        int unsigned span;
        int unsigned fin;
        int unsigned expl;
        bit          ovf;
        placement_t  p;
        ovf = 1'b0;
        if (!lay_open)
            open_struct();
        // arg-stack mode overrides every member's explicit alignment
        expl = cfg_arg_stack ? 32'(ARG_STACK_ALIGN) : 32'(m.expl);
        if (expl > 0) begin
            ia = 32'(clamp_al(expl));
            if (32'(lay_pack) < ia)
                lay_pack = ALIGN_W'(ia);
        end else begin
            ia = 32'(clamp_al(32'(m.align)));
        end
        if (32'(lay_max_align) < ia)
            lay_max_align = ALIGN_W'(ia);

        off = ceil_mult(32'(lay_offset), ia);
        if (off > SAT_MAX) begin
            off = SAT_MAX;
            ovf = 1'b1;
        end
        if (cfg_union) begin
            // offset never moves, size is the widest member
            if (lay_size < (SIZE_W+1)'(m.size))
                lay_size = (SIZE_W+1)'(m.size);
        end else begin
            span = off + 32'(m.size);
            if (span > SAT_MAX) begin
                span = SAT_MAX;
                ovf  = 1'b1;
            end
            lay_offset = (SIZE_W+1)'(span);
            lay_size   = (SIZE_W+1)'(span);
        end

        // first error of the struct sticks
        if (!m.complete && lay_err == STAT_OK)
            lay_err = STAT_INCOMPLETE;
        if (ovf && lay_err == STAT_OK)
            lay_err = STAT_OVERFLOW;

        p.align = (lay_max_align < lay_pack) ? lay_max_align : lay_pack;
        fin = 32'(lay_size);
        if (m.last) begin
            fin = ceil_mult(32'(lay_size), 32'(p.align));
            if (fin > SAT_MAX) begin
                fin = SAT_MAX;
                if (lay_err == STAT_OK)
                    lay_err = STAT_OVERFLOW;
            end
            lay_open = 1'b0;
        end
        p.offset = SIZE_W'(off);
        p.size   = SIZE_W'(fin);
        p.status = lay_err;
        p.last   = m.last;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on input beats, compare on result beats.
    // Everything here samples pre-edge values.
    // ------------------------------------------------------------------
    task automatic flag_error(input string why, input placement_t want, input placement_t got);
        fail_count++;
        if (fail_count <= SHOWN_MAX)
            $display({"[%0t] %s: expected off=%0d size=%0d align=%0d status=%0d last=%0d,",
                      " got off=%0d size=%0d align=%0d status=%0d last=%0d"},
                     $time, why, want.offset, want.size, want.align, want.status,
                     want.last, got.offset, got.size, got.align, got.status, got.last);
    endtask

    always @(posedge aclk) begin : scoreboard
        placement_t want;
        placement_t got;
        member_t    mem;
        pin_t       pin;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.offset = m_member_offset;
                got.size   = m_struct_size;
                got.align  = m_struct_align;
                got.status = m_status;
                got.last   = m_last;
                if (placement_q.size() == 0) begin
                    flag_error("result beat with nothing outstanding", '0, got);
                end else begin
                    want = placement_q.pop_front();
                    if (got.offset !== want.offset || got.size !== want.size ||
                        got.align !== want.align || got.status !== want.status ||
                        got.last !== want.last)
                        flag_error("layout mismatch", want, got);
                end
            end
            if (s_valid && s_ready) begin
                mem.size     = s_member_size;
                mem.align    = s_member_align;
                mem.expl     = s_member_explicit_align;
                mem.complete = s_member_complete;
                mem.last     = s_last_member;
                // predictor always runs so its state tracks the block
                want = place_member(mem);
                if (pinned_q.size() > 0) begin
                    pin = pinned_q.pop_front();
                    if (pin.pinned)
                        want = pin.want;
                end
                placement_q.insert(placement_q.size(), want);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog: any beat or register access counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("struct_layout_offsets verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers (called at a rising edge, drive with NBAs)
    // ------------------------------------------------------------------
    task automatic send_member(input member_t m, input bit pinned, input placement_t want);
        pin_t pin;
        pin.pinned = pinned;
        pin.want   = want;
        pinned_q.insert(pinned_q.size(), pin);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid                 <= 1'b1;
        s_member_size           <= m.size;
        s_member_align          <= m.align;
        s_member_explicit_align <= m.expl;
        s_member_complete       <= m.complete;
        s_last_member           <= m.last;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Drop valid and wait until every expected beat is back; checked at the
    // falling edge so the scoreboard's work for the edge is done
    task automatic wait_idle();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (placement_q.size() != 0);
        @(posedge aclk);
    endtask

    // APB write: setup phase, then access until pready, then back to idle
    task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PACK:         cfg_pack         = val[ALIGN_W-1:0];
            REG_STRUCT_ALIGN: cfg_struct_align = val[ALIGN_W-1:0];
            REG_UNION:        cfg_union        = val[0];
            REG_ARG_STACK:    cfg_arg_stack    = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    task automatic add_cfg(input logic [REGIDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        row_t r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.mem     = '0;
        r.pinned  = 1'b0;
        r.want    = '0;
        directed.insert(directed.size(), r);
    endtask

    task automatic add_mem(input logic [SIZE_W-1:0] size, input logic [ALIGN_W-1:0] align,
                           input logic [ALIGN_W-1:0] expl, input logic complete,
                           input logic last);
        row_t r;
        r.kind         = ROW_MEMBER;
        r.reg_idx      = '0;
        r.reg_val      = '0;
        r.mem.size     = size;
        r.mem.align    = align;
        r.mem.expl     = expl;
        r.mem.complete = complete;
        r.mem.last     = last;
        r.pinned       = 1'b0;
        r.want         = '0;
        directed.insert(directed.size(), r);
    endtask

    task automatic add_chk(input logic [SIZE_W-1:0] size, input logic [ALIGN_W-1:0] align,
                           input logic [ALIGN_W-1:0] expl, input logic complete,
                           input logic last, input logic [SIZE_W-1:0] off,
                           input logic [SIZE_W-1:0] ssize, input logic [ALIGN_W-1:0] salign,
                           input logic [STATUS_W-1:0] st);
        add_mem(size, align, expl, complete, last);
        directed[directed.size()-1].pinned      = 1'b1;
        directed[directed.size()-1].want.offset = off;
        directed[directed.size()-1].want.size   = ssize;
        directed[directed.size()-1].want.align  = salign;
        directed[directed.size()-1].want.status = st;
        directed[directed.size()-1].want.last   = last;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    // mostly powers of two, some zero, some anything the 7 bits allow
    function automatic logic [ALIGN_W-1:0] pick_align();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55)
            return ALIGN_W'(1 << $urandom_range(0, 6));
        if (p < 65)
            return '0;
        return ALIGN_W'($urandom_range(0, 127));
    endfunction

    function automatic member_t random_member(input bit last);
        member_t     m;
        int unsigned p;
        p = $urandom_range(99);
        if (p < 50)
            m.size = SIZE_W'($urandom_range(0, 64));
        else if (p < 80)
            m.size = SIZE_W'($urandom_range(0, 4096));
        else
            m.size = SIZE_W'($urandom_range(0, 65535));   // overflow territory
        m.align    = pick_align();
        m.expl     = ($urandom_range(99) < 60) ? '0 : pick_align();
        m.complete = ($urandom_range(99) >= 8);
        m.last     = last;
        return m;
    endfunction

    // New setting for all four registers; unused upper data bits carry noise
    task automatic random_layout_cfg();
        logic [DATA_W-1:0] noise;
        wait_idle();
        noise = $urandom();
        write_reg(REG_PACK, (noise & ~32'h7F) | DATA_W'(pick_align()));
        noise = $urandom();
        write_reg(REG_STRUCT_ALIGN, (noise & ~32'h7F) |
                  DATA_W'(($urandom_range(99) < 40) ? '0 : pick_align()));
        noise = $urandom();
        write_reg(REG_UNION, (noise & ~32'h1) | DATA_W'($urandom_range(99) < 25));
        noise = $urandom();
        write_reg(REG_ARG_STACK, (noise & ~32'h1) | DATA_W'($urandom_range(99) < 25));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int budget;
        int len;

        // Reset defaults: pack 8, no explicit align, struct mode
        add_chk(1, 1, 0, 1, 0,  0, 1, 1, STAT_OK);
        add_chk(4, 4, 0, 1, 0,  4, 8, 4, STAT_OK);
        add_chk(2, 8, 0, 1, 1,  8, 16, 8, STAT_OK);       // final size rounded to 8
        add_chk(3, 2, 0, 0, 1,  0, 4, 2, STAT_INCOMPLETE);
        // zero alignment, zero size, odd alignment, alignment past the ceiling
        add_mem(5, 0, 0, 1, 0);
        add_mem(0, 3, 0, 1, 0);
        add_mem(1, 127, 0, 1, 1);
        // offset overflow saturates
        add_chk(16'hFFFF, 1, 0, 1, 0,  0, 16'hFFFF, 1, STAT_OK);
        add_chk(1, 2, 0, 1, 1,  16'hFFFF, 16'hFFFF, 2, STAT_OVERFLOW);
        // member explicit alignment lifts the pack; clamped at the ceiling
        add_chk(1, 1, 16, 1, 1,  0, 16, 16, STAT_OK);
        add_chk(16'hFFFF, 1, 127, 1, 1,  0, 16'hFFFF, 64, STAT_OVERFLOW);
        // incomplete first, later overflow must not replace it
        add_chk(10, 1, 0, 0, 0,  0, 10, 1, STAT_INCOMPLETE);
        add_chk(16'hFFFF, 1, 0, 1, 1,  10, 16'hFFFF, 1, STAT_INCOMPLETE);
        // pack of zero acts as 1
        add_cfg(REG_PACK, 0);
        add_mem(3, 8, 0, 1, 0);
        add_mem(1, 4, 0, 1, 1);
        // pack beyond the ceiling, struct explicit alignment
        add_cfg(REG_PACK, 127);
        add_cfg(REG_STRUCT_ALIGN, 32);
        add_mem(1, 1, 0, 1, 1);
        add_cfg(REG_PACK, 1);
        add_cfg(REG_STRUCT_ALIGN, 127);
        add_mem(2, 2, 0, 1, 1);
        // union layout
        add_cfg(REG_STRUCT_ALIGN, 0);
        add_cfg(REG_UNION, 1);
        add_mem(10, 4, 0, 1, 0);
        add_mem(100, 2, 0, 1, 0);
        add_mem(7, 16, 0, 1, 1);
        // argument-stack mode forces 4 regardless of member alignment
        add_cfg(REG_UNION, 0);
        add_cfg(REG_ARG_STACK, 1);
        add_cfg(REG_PACK, 64);
        add_mem(1, 64, 0, 1, 0);
        add_mem(8, 8, 32, 1, 1);
        add_cfg(REG_ARG_STACK, 0);
        add_cfg(REG_PACK, 8);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                send_member(directed[i].mem, directed[i].pinned, directed[i].want);
            end
        end

        // Three back-pressure regimes, five register settings each, whole
        // structs only so settings change between structs
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 71;
                end
                1: begin
                    tx_idle_pct = 71;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int setting = 0; setting < 5; setting++) begin
                random_layout_cfg();
                budget = 25;
                while (budget > 0) begin
                    len = ($urandom_range(99) < 80) ? $urandom_range(1, 6)
                                                    : $urandom_range(7, 20);
                    for (int k = 0; k < len; k++)
                        send_member(random_member(k == len - 1), 1'b0, '0);
                    budget -= len;
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("struct_layout_offsets verification clean");
        end else begin
            $display("struct_layout_offsets verification failed");
        end
        $finish;
    end

endmodule
